FILE: design/cpt_pkg.sv
package cpt_pkg;
   localparam logic [1:0] REQ_TOUCH  = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_ACTIVE = 2'd2;
   localparam logic [1:0] REQ_REMOVE = 2'd3;

   localparam logic [2:0] EV_ENTER       = 3'd0;
   localparam logic [2:0] EV_CONTACT     = 3'd1;
   localparam logic [2:0] EV_LEAVE       = 3'd2;
   localparam logic [2:0] EV_ACTIVATED   = 3'd3;
   localparam logic [2:0] EV_DEACTIVATED = 3'd4;
   localparam logic [2:0] EV_DROP        = 3'd5;

   localparam logic [1:0] CSR_TYPE_MASK = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_PERIOD    = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] object_id;
      logic [31:0] now;
      logic        activate_value;
   } cmd_type;
endpackage

FILE: design/cpt_front.sv
module cpt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [1:0]              in_kind,
   input  logic [15:0]             in_object,
   input  logic [31:0]             in_type,
   input  logic [31:0]             in_now,
   input  logic                    in_act,
   input  logic [31:0]             type_mask,
   output logic                    q_valid,
   input  logic                    q_ready,
   output cpt_pkg::cmd_type        q_cmd
);
   import cpt_pkg::*;
   localparam int QD = 2;
   cmd_type q_ff [QD];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       keep, push, pop;

   // touches that cannot interact are dropped here
   assign keep = !(in_kind == REQ_TOUCH && (in_type & type_mask) == 32'd0);
   assign in_ready = cnt_ff != 2'(QD);
   assign push = in_valid && in_ready && keep;
   assign pop = q_valid && q_ready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd = q_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
      end
      if (push) q_ff[wr_ff] <= '{in_kind, in_object, in_now, in_act};
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QD))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'(QD) && !pop) |=> cnt_ff == 2'(QD))
      else $error("queue lost entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !q_valid)
      else $error("empty queue valid");
endmodule

FILE: design/cpt_back.sv
module cpt_back #(
   parameter int TABLE_DEPTH = 16,
   parameter int OBJECT_ID_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  cpt_pkg::cmd_type  q_cmd,
   input  logic [15:0]       timeout_ticks,
   input  logic [15:0]       period_ticks,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        out_code,
   output logic [15:0]       out_object,
   output logic              out_last
);
   import cpt_pkg::*;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [2:0] S_IDLE = 3'd0, S_TOUCH = 3'd1, S_TICK = 3'd2,
      S_SHIFT = 3'd3, S_DEACT = 3'd4, S_REMOVE = 3'd5, S_EMIT = 3'd6;

   logic [OBJECT_ID_BITS-1:0] obj_ff [TABLE_DEPTH];
   logic [31:0] exp_ff [TABLE_DEPTH];
   logic [31:0] due_ff [TABLE_DEPTH];
   logic [2:0]  st_ff;
   logic [CW-1:0] cnt_ff, idx_ff, sh_ff;
   logic        act_ff, pend_ff;
   logic [2:0]  pcode_ff;
   logic [15:0] pobj_ff;
   cmd_type     cmd_ff;
   logic        ov_ff, last_ff;
   logic [2:0]  code_ff;
   logic [15:0] eobj_ff;
   logic [OBJECT_ID_BITS-1:0] key;
   logic [IW-1:0] ix, sx;
   logic [OBJECT_ID_BITS-1:0] cur_obj;
   logic [31:0] cur_exp, cur_due;
   logic [31:0] exp_diff, con_diff;
   logic        at_end, exp_due, con_due;
   logic        free, emit, ov_in;

   assign key = OBJECT_ID_BITS'(cmd_ff.object_id);
   assign ix = idx_ff[IW-1:0];
   assign sx = sh_ff[IW-1:0];
   assign cur_obj = obj_ff[ix];
   assign cur_exp = exp_ff[ix];
   assign cur_due = due_ff[ix];
   assign at_end = idx_ff >= cnt_ff;
   assign exp_diff = cmd_ff.now - cur_exp;
   assign con_diff = cmd_ff.now - cur_due;
   assign exp_due = !exp_diff[31];
   assign con_due = !con_diff[31];
   assign q_ready = st_ff == S_IDLE;
   assign out_valid = ov_ff;
   assign out_code = code_ff;
   assign out_object = eobj_ff;
   assign out_last = last_ff;
   assign free = !ov_ff || out_ready;

   always_comb begin
      emit = 1'b0;
      unique case (st_ff)
         S_TOUCH: emit = at_end && free;
         S_TICK: emit = free && pend_ff && (at_end || exp_due || con_due);
         S_DEACT, S_EMIT: emit = free;
         default: emit = 1'b0;
      endcase
   end

   assign ov_in = emit || (ov_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         act_ff <= 1'b1;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               cmd_ff <= q_cmd;
               idx_ff <= '0;
               pend_ff <= 1'b0;
               unique case (q_cmd.kind)
                  REQ_TOUCH: st_ff <= act_ff ? S_TOUCH : S_IDLE;
                  REQ_TICK: st_ff <= S_TICK;
                  REQ_ACTIVE: if (q_cmd.activate_value != act_ff) begin
                     act_ff <= q_cmd.activate_value;
                     if (q_cmd.activate_value) st_ff <= S_EMIT;
                     else st_ff <= S_DEACT;
                  end
                  REQ_REMOVE: st_ff <= S_REMOVE;
                  default: st_ff <= S_IDLE;
               endcase
            end
            S_TOUCH: begin
               if (at_end) begin
                  if (free) begin
                     eobj_ff <= 16'(key);
                     last_ff <= 1'b1; st_ff <= S_IDLE;
                     if (cnt_ff == CW'(TABLE_DEPTH)) code_ff <= EV_DROP;
                     else begin
                        code_ff <= EV_ENTER;
                        obj_ff[cnt_ff[IW-1:0]] <= key;
                        exp_ff[cnt_ff[IW-1:0]] <= cmd_ff.now + 32'(timeout_ticks);
                        due_ff[cnt_ff[IW-1:0]] <= cmd_ff.now + 32'(period_ticks);
                        cnt_ff <= cnt_ff + 1'b1;
                     end
                  end
               end else if (cur_obj == key) begin
                  exp_ff[ix] <= cmd_ff.now + 32'(timeout_ticks);
                  st_ff <= S_IDLE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_TICK: if (free) begin
               if (at_end) begin
                  if (pend_ff) begin
                     code_ff <= pcode_ff; eobj_ff <= pobj_ff; last_ff <= 1'b1;
                  end
                  st_ff <= S_IDLE;
               end else begin
                  // hold the newest event until the next one shows whether it is last
                  if (exp_due || con_due) begin
                     if (pend_ff) begin
                        code_ff <= pcode_ff; eobj_ff <= pobj_ff; last_ff <= 1'b0;
                     end
                     pend_ff <= 1'b1;
                     pcode_ff <= exp_due ? EV_LEAVE : EV_CONTACT;
                     pobj_ff <= 16'(cur_obj);
                  end
                  if (exp_due) begin
                     sh_ff <= idx_ff; st_ff <= S_SHIFT;
                  end else begin
                     if (con_due) due_ff[ix] <= cmd_ff.now + 32'(period_ticks);
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_SHIFT, S_REMOVE: begin
               if (st_ff == S_REMOVE && !at_end && cur_obj != key) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (st_ff == S_REMOVE && at_end) begin
                  st_ff <= S_IDLE;
               end else begin
                  if (st_ff == S_REMOVE) begin sh_ff <= idx_ff; st_ff <= S_SHIFT; end
                  else if (sh_ff + 1'b1 < cnt_ff) begin
                     obj_ff[sx] <= obj_ff[IW'(sh_ff + 1'b1)];
                     exp_ff[sx] <= exp_ff[IW'(sh_ff + 1'b1)];
                     due_ff[sx] <= due_ff[IW'(sh_ff + 1'b1)];
                     sh_ff <= sh_ff + 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff - 1'b1;
                     st_ff <= (cmd_ff.kind == REQ_TICK) ? S_TICK : S_IDLE;
                  end
               end
            end
            S_DEACT: if (free) begin
               if (cnt_ff != '0) begin
                  code_ff <= EV_LEAVE;
                  eobj_ff <= 16'(obj_ff[IW'(cnt_ff - 1'b1)]);
                  last_ff <= 1'b0;
                  cnt_ff <= cnt_ff - 1'b1;
               end else begin
                  code_ff <= EV_DEACTIVATED; eobj_ff <= '0; last_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end
            end
            S_EMIT: if (free) begin
               code_ff <= EV_ACTIVATED; eobj_ff <= '0; last_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(TABLE_DEPTH))
      else $error("count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> (ov_ff && $stable(code_ff) && $stable(eobj_ff)))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (q_ready && q_valid) |=> st_ff != S_IDLE || $stable(cnt_ff))
      else $error("idle changed count");
endmodule

FILE: design/contact_presence_table_top.sv
// an activation, or a touch on an empty table, passes the front queue, the command
// register and the result register; touch and remove search one entry a cycle; while
// the output is not stalled, deactivation gives one leave a cycle and a tick walks one
// entry a cycle; each removal shifts the table one entry a cycle
// the table engine takes one transaction at a time, with a 2-deep queue ahead
// reset: synchronous, active high; table empty, active, registers at defaults
module contact_presence_table_top #(
   parameter int TABLE_DEPTH = 16,
   parameter int OBJECT_ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        s_axis_tvalid,
   output logic        s_axis_tready,
   input  logic [1:0]  s_axis_tuser,  // req_type
   input  logic [87:0] s_axis_tdata,  // object_id, object_type, now, activate_value, pad
   output logic        m_axis_tvalid,
   input  logic        m_axis_tready,
   output logic [23:0] m_axis_tdata,  // event_code, event_object, pad
   output logic        m_axis_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import cpt_pkg::*;
   logic [31:0] mask_ff;
   logic [15:0] tmo_ff, per_ff;
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   logic [2:0]  code;
   logic [15:0] eobj;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1; tmo_ff <= 16'd250; per_ff <= 16'd250;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TYPE_MASK: mask_ff <= csr_wdata;
            CSR_TIMEOUT: tmo_ff <= csr_wdata[15:0];
            CSR_PERIOD: per_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   cpt_front u_front (
      .clock, .reset, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
      .in_kind(s_axis_tuser), .in_object(s_axis_tdata[15:0]),
      .in_type(s_axis_tdata[47:16]), .in_now(s_axis_tdata[79:48]),
      .in_act(s_axis_tdata[80]), .type_mask(mask_ff),
      .q_valid, .q_ready, .q_cmd
   );

   cpt_back #(.TABLE_DEPTH(TABLE_DEPTH), .OBJECT_ID_BITS(OBJECT_ID_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .timeout_ticks(tmo_ff), .period_ticks(per_ff),
      .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
      .out_code(code), .out_object(eobj), .out_last(m_axis_tlast)
   );

   assign m_axis_tdata = {5'd0, eobj, code};
endmodule
